/* src/pnrf_pkg.sv */
`default_nettype none
package pnrf_pkg;

    localparam int STORE_BYTES_DEF = 32768;

    localparam int CMD_W    = 3;
    localparam int X_W      = 9;
    localparam int Y_W      = 8;
    localparam int WID_W    = 10;
    localparam int HGT_W    = 9;
    localparam int COLOR_W  = 4;
    localparam int BYTE_W   = 8;
    localparam int BPL_W    = 8;
    localparam int PX_W     = 11;
    localparam int ROW_W    = 10;
    localparam int COL_W    = PX_W - 1;
    localparam int PROD_W   = ROW_W + BPL_W;
    localparam int ADDR_W   = PROD_W + 1;
    localparam int SEG_W    = 9;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_LINE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DRAW_COLOR     = 1'd1;

    localparam logic [BPL_W-1:0]   BPL_RESET   = 8'd128;
    localparam logic [COLOR_W-1:0] COLOR_RESET = 4'hF;

    localparam logic [CMD_W-1:0] CMD_HLINE = 3'd0;
    localparam logic [CMD_W-1:0] CMD_VLINE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_BAR   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_RECT  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ  = 3'd4;

    localparam logic [BYTE_W-1:0]  NIB_HI_MASK = 8'hF0;
    localparam logic [BYTE_W-1:0]  NIB_LO_MASK = 8'h0F;
    localparam logic [COLOR_W-1:0] COLOR_MASK  = 4'hF;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] wdata;
    } mem_req_t;

endpackage
`default_nettype wire

/* src/pnrf_if.sv */
`default_nettype none
interface pnrf_cmd_if
    import pnrf_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   command;
    logic [X_W-1:0]     x_pos;
    logic [Y_W-1:0]     y_pos;
    logic [WID_W-1:0]   width;
    logic [HGT_W-1:0]   height;
    logic [COLOR_W-1:0] color;

    modport source (output valid, command, x_pos, y_pos, width, height, color,
                    input ready);
    modport sink   (input valid, command, x_pos, y_pos, width, height, color,
                    output ready);
endinterface

interface pnrf_res_if
    import pnrf_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] read_data;
    logic              status;

    modport source (output valid, read_data, status, input ready);
    modport sink   (input valid, read_data, status, output ready);
endinterface
`default_nettype wire

/* src/pnrf_addr.sv */
`default_nettype none
module pnrf_addr
    import pnrf_pkg::*;
#(
    parameter int STORE_BYTES = STORE_BYTES_DEF
) (
    input  wire logic              clk,
    input  wire logic [PX_W-1:0]   px,
    input  wire logic [ROW_W-1:0]  row,
    input  wire logic [BPL_W-1:0]  bpl,
    output logic      [ADDR_W-1:0] addr,
    output logic                   oob
);

    logic [PROD_W-1:0] prod_reg;
    logic [COL_W-1:0]  col_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(row) * PROD_W'(bpl);
        col_reg  <= px[PX_W-1:1];
    end

    assign addr = ADDR_W'(prod_reg) + ADDR_W'(col_reg);
    assign oob  = (addr >= ADDR_W'(STORE_BYTES));

endmodule
`default_nettype wire

/* src/pnrf_mem.sv */
`default_nettype none
module pnrf_mem
    import pnrf_pkg::*;
#(
    parameter int STORE_BYTES = STORE_BYTES_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire mem_req_t          req,
    output logic      [BYTE_W-1:0] rdata,
    output logic                   busy
);

    localparam int IDX_W = $clog2(STORE_BYTES);

    logic [BYTE_W-1:0] frame_store [STORE_BYTES];
    logic [BYTE_W-1:0] rdata_reg;
    logic [IDX_W-1:0]  clr_cnt_reg;
    logic              clearing_reg;

    // zero sweep after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg  <= '0;
            clearing_reg <= 1'b1;
        end
        else if (clearing_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == IDX_W'(STORE_BYTES - 1))
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            frame_store[clr_cnt_reg] <= '0;
        end
        else if (req.we)
        begin
            frame_store[req.addr[IDX_W-1:0]] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= frame_store[req.addr[IDX_W-1:0]];
        end
    end

    assign rdata = rdata_reg;
    assign busy  = clearing_reg;

endmodule
`default_nettype wire

/* src/pnrf_seq.sv */
`default_nettype none
module pnrf_seq
    import pnrf_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               busy,
    input  wire logic [COLOR_W-1:0] draw_color,
    pnrf_cmd_if.sink                cmd,
    pnrf_res_if.source              res,
    output logic      [PX_W-1:0]    px,
    output logic      [ROW_W-1:0]   row,
    input  wire logic [ADDR_W-1:0]  addr,
    input  wire logic               oob,
    output mem_req_t                mem_req,
    input  wire logic [BYTE_W-1:0]  mem_rdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_MUL,
        S_ADDR,
        S_MERGE,
        S_READ,
        S_DONE
    } state_t;

    state_t             state_reg,   state_next;
    logic [CMD_W-1:0]   cmd_reg,     cmd_next;
    logic [X_W-1:0]     x_reg,       x_next;
    logic [Y_W-1:0]     y_reg,       y_next;
    logic [WID_W-1:0]   w_reg,       w_next;
    logic [HGT_W-1:0]   h_reg,       h_next;
    logic [COLOR_W-1:0] pen_reg,     pen_next;
    logic [SEG_W-1:0]   seg_reg,     seg_next;
    logic [SEG_W-1:0]   seg_cnt_reg, seg_cnt_next;
    logic [PX_W-1:0]    px_reg,      px_next;
    logic [ROW_W-1:0]   row_reg,     row_next;
    logic [WID_W-1:0]   rem_reg,     rem_next;
    logic               horiz_reg,   horiz_next;
    logic               bad_reg,     bad_next;
    logic [BYTE_W-1:0]  rd_reg,      rd_next;
    logic [ADDR_W-1:0]  addr_reg,    addr_next;

    logic [PX_W-1:0]    ld_px;
    logic [ROW_W-1:0]   ld_row;
    logic [WID_W-1:0]   ld_rem;
    logic               ld_horiz;
    logic               adv;
    logic               adv2;
    logic [1:0]         step;

    always_comb
    begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        w_next       = w_reg;
        h_next       = h_reg;
        pen_next     = pen_reg;
        seg_next     = seg_reg;
        seg_cnt_next = seg_cnt_reg;
        px_next      = px_reg;
        row_next     = row_reg;
        rem_next     = rem_reg;
        horiz_next   = horiz_reg;
        bad_next     = bad_reg;
        rd_next      = rd_reg;
        addr_next    = addr_reg;
        mem_req      = '0;
        adv          = 1'b0;
        adv2         = 1'b0;
        step         = 2'd1;
        ld_px        = PX_W'(x_reg);
        ld_row       = ROW_W'(y_reg);
        ld_rem       = '0;
        ld_horiz     = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid && !busy)
                begin
                    cmd_next = cmd.command;
                    x_next   = cmd.x_pos;
                    y_next   = cmd.y_pos;
                    w_next   = cmd.width;
                    h_next   = cmd.height;
                    bad_next = 1'b0;
                    rd_next  = '0;
                    seg_next = '0;
                    pen_next = draw_color;
                    case (cmd.command)
                        CMD_HLINE, CMD_VLINE:
                        begin
                            pen_next     = cmd.color & COLOR_MASK;
                            seg_cnt_next = SEG_W'(1);
                        end
                        CMD_READ: seg_cnt_next = SEG_W'(1);
                        CMD_BAR:
                        begin
                            seg_cnt_next = (cmd.width != '0) ? SEG_W'(cmd.height) : '0;
                        end
                        CMD_RECT:
                        begin
                            seg_cnt_next = (cmd.width != '0 && cmd.height != '0)
                                           ? SEG_W'(4) : '0;
                        end
                        default: seg_cnt_next = '0;
                    endcase
                    state_next = S_LOAD;
                end
            end

            S_LOAD:
            begin
                case (cmd_reg)
                    CMD_HLINE: ld_rem = w_reg;
                    CMD_VLINE:
                    begin
                        ld_rem   = WID_W'(h_reg);
                        ld_horiz = 1'b0;
                    end
                    CMD_BAR:
                    begin
                        ld_row = ROW_W'(y_reg) + ROW_W'(seg_reg);
                        ld_rem = w_reg;
                    end
                    CMD_RECT:
                    begin
                        case (seg_reg[1:0])
                            2'd0: ld_rem = w_reg;
                            2'd1:
                            begin
                                ld_row = ROW_W'(y_reg) + ROW_W'(h_reg) - ROW_W'(1);
                                ld_rem = w_reg;
                            end
                            2'd2:
                            begin
                                ld_rem   = WID_W'(h_reg);
                                ld_horiz = 1'b0;
                            end
                            default:
                            begin
                                ld_px    = PX_W'(x_reg) + PX_W'(w_reg) - PX_W'(1);
                                ld_rem   = WID_W'(h_reg);
                                ld_horiz = 1'b0;
                            end
                        endcase
                    end
                    CMD_READ: ld_rem = WID_W'(1);
                    default:  ld_rem = '0;
                endcase

                if (seg_reg == seg_cnt_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    seg_next   = seg_reg + 1'b1;
                    px_next    = ld_px;
                    row_next   = ld_row;
                    rem_next   = ld_rem;
                    horiz_next = ld_horiz;
                    state_next = (ld_rem == '0) ? S_LOAD : S_MUL;
                end
            end

            S_MUL: state_next = S_ADDR;

            S_ADDR:
            begin
                if (cmd_reg == CMD_READ)
                begin
                    if (oob)
                    begin
                        bad_next   = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        mem_req.re   = 1'b1;
                        mem_req.addr = addr;
                        state_next   = S_READ;
                    end
                end
                else if (oob)
                begin
                    bad_next = 1'b1;
                    adv      = 1'b1;
                end
                else if (horiz_reg && !px_reg[0] && rem_reg >= WID_W'(2))
                begin
                    // both nibbles covered: plain byte write
                    mem_req.we    = 1'b1;
                    mem_req.addr  = addr;
                    mem_req.wdata = {pen_reg, pen_reg};
                    adv           = 1'b1;
                    adv2          = 1'b1;
                end
                else
                begin
                    mem_req.re   = 1'b1;
                    mem_req.addr = addr;
                    addr_next    = addr;
                    state_next   = S_MERGE;
                end
            end

            S_MERGE:
            begin
                mem_req.we   = 1'b1;
                mem_req.addr = addr_reg;
                if (px_reg[0])
                begin
                    mem_req.wdata = (mem_rdata & NIB_HI_MASK) | BYTE_W'(pen_reg);
                end
                else
                begin
                    mem_req.wdata = (mem_rdata & NIB_LO_MASK) | {pen_reg, 4'h0};
                end
                adv = 1'b1;
            end

            S_READ:
            begin
                rd_next    = mem_rdata;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (res.ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase

        if (adv)
        begin
            step = adv2 ? 2'd2 : 2'd1;
            if (horiz_reg)
            begin
                px_next  = px_reg + PX_W'(step);
                rem_next = rem_reg - WID_W'(step);
            end
            else
            begin
                row_next = row_reg + 1'b1;
                rem_next = rem_reg - 1'b1;
            end
            state_next = (rem_next == '0) ? S_LOAD : S_MUL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cmd_reg     <= '0;
            x_reg       <= '0;
            y_reg       <= '0;
            w_reg       <= '0;
            h_reg       <= '0;
            pen_reg     <= '0;
            seg_reg     <= '0;
            seg_cnt_reg <= '0;
            px_reg      <= '0;
            row_reg     <= '0;
            rem_reg     <= '0;
            horiz_reg   <= 1'b0;
            bad_reg     <= 1'b0;
            rd_reg      <= '0;
            addr_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            cmd_reg     <= cmd_next;
            x_reg       <= x_next;
            y_reg       <= y_next;
            w_reg       <= w_next;
            h_reg       <= h_next;
            pen_reg     <= pen_next;
            seg_reg     <= seg_next;
            seg_cnt_reg <= seg_cnt_next;
            px_reg      <= px_next;
            row_reg     <= row_next;
            rem_reg     <= rem_next;
            horiz_reg   <= horiz_next;
            bad_reg     <= bad_next;
            rd_reg      <= rd_next;
            addr_reg    <= addr_next;
        end
    end

    assign cmd.ready     = (state_reg == S_IDLE) && !busy;
    assign res.valid     = (state_reg == S_DONE);
    assign res.read_data = rd_reg;
    assign res.status    = bad_reg;
    assign px            = px_reg;
    assign row           = row_reg;

endmodule
`default_nettype wire

/* src/packed_nibble_rect_fill_unit.sv */
`default_nettype none
// 4-bit-per-pixel drawing unit over an internal framebuffer of STORE_BYTES
// bytes, two pixels per byte, even column in the high nibble. One item is
// taken at a time and gives one result item. After reset the store is swept
// to zero one byte per cycle, and no item is accepted until the sweep ends;
// configuration writes are taken throughout. Each pixel goes through one
// shared multiply-add-compare address unit and one memory port: a pixel that
// needs a read-modify-write passes the multiply, address and merge states, a
// whole byte of a horizontal run or a pixel outside the store the multiply and
// address states, and each drawn segment (row of a bar, side of a rectangle)
// adds a load state. A byte read passes load, multiply, address and read.
module packed_nibble_rect_fill_unit
    import pnrf_pkg::*;
#(
    parameter int STORE_BYTES = STORE_BYTES_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    pnrf_cmd_if.sink                   cmd,
    pnrf_res_if.source                 res,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    logic [BPL_W-1:0]   bpl_reg;
    logic [COLOR_W-1:0] draw_color_reg;
    logic [PX_W-1:0]    px;
    logic [ROW_W-1:0]   row;
    logic [ADDR_W-1:0]  addr;
    logic               oob;
    logic               busy;
    mem_req_t           mem_req;
    logic [BYTE_W-1:0]  mem_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpl_reg        <= BPL_RESET;
            draw_color_reg <= COLOR_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BYTES_PER_LINE: bpl_reg        <= cfg_data[BPL_W-1:0];
                REG_DRAW_COLOR:     draw_color_reg <= cfg_data[COLOR_W-1:0];
                default:            ;
            endcase
        end
    end

    pnrf_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .busy       (busy),
        .draw_color (draw_color_reg),
        .cmd        (cmd),
        .res        (res),
        .px         (px),
        .row        (row),
        .addr       (addr),
        .oob        (oob),
        .mem_req    (mem_req),
        .mem_rdata  (mem_rdata)
    );

    pnrf_addr #(
        .STORE_BYTES (STORE_BYTES)
    ) u_addr (
        .clk  (clk),
        .px   (px),
        .row  (row),
        .bpl  (bpl_reg),
        .addr (addr),
        .oob  (oob)
    );

    pnrf_mem #(
        .STORE_BYTES (STORE_BYTES)
    ) u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mem_req),
        .rdata (mem_rdata),
        .busy  (busy)
    );

endmodule
`default_nettype wire

/* sim/packed_nibble_rect_fill_unit_tb.sv */
`timescale 1ns / 100ps
module packed_nibble_rect_fill_unit_tb;
    import pnrf_pkg::*;

    localparam int DIR_ROWS     = 25;
    localparam int PHASES       = 7;
    localparam int PHASE_ITEMS  = 122;
    localparam int DRAIN_CYCLES = 16;

    localparam logic [CMD_W-1:0] CMD_SPARE_LO = CMD_READ + 3'd1;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = CMD_READ + 3'd3;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [X_W-1:0]     x_pos;
        logic [Y_W-1:0]     y_pos;
        logic [WID_W-1:0]   width;
        logic [HGT_W-1:0]   height;
        logic [COLOR_W-1:0] color;
    } draw_cmd_t;

    typedef struct packed {
        logic [BYTE_W-1:0] read_data;
        logic              status;
    } draw_result_t;

    typedef struct packed {
        draw_cmd_t    cmd;
        logic         fixed;
        draw_result_t want;
    } dir_row_t;

    // fixed rows carry a hand-written result; the rest go through the predictor
    dir_row_t directed_rows [DIR_ROWS] = '{
        '{'{CMD_READ,     9'd0,   8'd0,   10'd0,    9'd0,   4'h0}, 1'b1, '{8'h00, 1'b0}},
        '{'{CMD_READ,     9'd511, 8'd255, 10'd0,    9'd0,   4'h0}, 1'b1, '{8'h00, 1'b1}},
        '{'{CMD_HLINE,    9'd0,   8'd0,   10'd0,    9'd256, 4'h5}, 1'b1, '{8'h00, 1'b0}},
        '{'{CMD_VLINE,    9'd7,   8'd3,   10'd512,  9'd0,   4'h9}, 1'b1, '{8'h00, 1'b0}},
        '{'{CMD_BAR,      9'd0,   8'd0,   10'd0,    9'd256, 4'h1}, 1'b1, '{8'h00, 1'b0}},
        '{'{CMD_BAR,      9'd4,   8'd4,   10'd512,  9'd0,   4'h1}, 1'b1, '{8'h00, 1'b0}},
        '{'{CMD_RECT,     9'd2,   8'd2,   10'd0,    9'd5,   4'h2}, 1'b1, '{8'h00, 1'b0}},
        '{'{CMD_RECT,     9'd2,   8'd2,   10'd5,    9'd0,   4'h2}, 1'b1, '{8'h00, 1'b0}},
        '{'{CMD_READ,     9'd511, 8'd0,   10'd0,    9'd0,   4'h0}, 1'b1, '{8'h00, 1'b0}},
        '{'{CMD_HLINE,    9'd1,   8'd0,   10'd6,    9'd0,   4'hA}, 1'b0, '{8'h00, 1'b0}},
        '{'{CMD_READ,     9'd0,   8'd0,   10'd0,    9'd0,   4'h0}, 1'b0, '{8'h00, 1'b0}},
        '{'{CMD_VLINE,    9'd3,   8'd1,   10'd0,    9'd4,   4'h5}, 1'b0, '{8'h00, 1'b0}},
        '{'{CMD_READ,     9'd2,   8'd3,   10'd0,    9'd0,   4'h0}, 1'b0, '{8'h00, 1'b0}},
        '{'{CMD_BAR,      9'd10,  8'd10,  10'd7,    9'd3,   4'h3}, 1'b0, '{8'h00, 1'b0}},
        '{'{CMD_RECT,     9'd20,  8'd20,  10'd9,    9'd5,   4'h4}, 1'b0, '{8'h00, 1'b0}},
        '{'{CMD_READ,     9'd28,  8'd24,  10'd0,    9'd0,   4'h0}, 1'b0, '{8'h00, 1'b0}},
        '{'{CMD_HLINE,    9'd511, 8'd255, 10'd1023, 9'd0,   4'hF}, 1'b1, '{8'h00, 1'b1}},
        '{'{CMD_VLINE,    9'd511, 8'd255, 10'd0,    9'd511, 4'h0}, 1'b1, '{8'h00, 1'b1}},
        '{'{CMD_RECT,     9'd511, 8'd255, 10'd1023, 9'd511, 4'h6}, 1'b1, '{8'h00, 1'b1}},
        '{'{CMD_SPARE_LO, 9'd511, 8'd255, 10'd1023, 9'd511, 4'hF}, 1'b1, '{8'h00, 1'b0}},
        '{'{CMD_SPARE_HI, 9'd0,   8'd0,   10'd0,    9'd0,   4'h0}, 1'b1, '{8'h00, 1'b0}},
        '{'{CMD_BAR,      9'd0,   8'd0,   10'd512,  9'd256, 4'h0}, 1'b0, '{8'h00, 1'b0}},
        '{'{CMD_READ,     9'd100, 8'd100, 10'd0,    9'd0,   4'h0}, 1'b0, '{8'h00, 1'b0}},
        '{'{CMD_HLINE,    9'd0,   8'd0,   10'd1,    9'd0,   4'h3}, 1'b0, '{8'h00, 1'b0}},
        '{'{CMD_READ,     9'd1,   8'd0,   10'd0,    9'd0,   4'h0}, 1'b0, '{8'h00, 1'b0}}
    };

    logic clk;
    logic rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    pnrf_cmd_if cmd_ch ();
    pnrf_res_if res_ch ();

    packed_nibble_rect_fill_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_ch),
        .res       (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    logic [BYTE_W-1:0]  frame_img [STORE_BYTES_DEF];
    logic [BPL_W-1:0]   line_stride;
    logic [COLOR_W-1:0] fill_color;

    draw_result_t pending_results [$];

    // hand-written expectation travels with the item
    logic              tag_fixed;
    draw_result_t      tag_want;

    int send_idle_pct;
    int stall_pct;
    int err_count;
    int items_in;
    int results_out;
    int reads_in;
    int flagged_in;
    int settings_done;

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic bit paint_nibble(input int unsigned px, input int unsigned row,
                                        input logic [COLOR_W-1:0] c);
        int unsigned addr;
        addr = row * line_stride + (px >> 1);
        if (addr >= STORE_BYTES_DEF)
            return 1'b1;
        if (px % 2 == 1)
            frame_img[addr] = (frame_img[addr] & NIB_HI_MASK) | {4'h0, c & COLOR_MASK};
        else
            frame_img[addr] = (frame_img[addr] & NIB_LO_MASK) | {c & COLOR_MASK, 4'h0};
        return 1'b0;
    endfunction

    function automatic bit paint_row(input int unsigned x, input int unsigned y,
                                     input int unsigned w, input logic [COLOR_W-1:0] c);
        bit bad;
        int unsigned i;
        bad = 1'b0;
        for (i = 0; i < w; i++)
            bad |= paint_nibble(x + i, y, c);
        return bad;
    endfunction

    function automatic bit paint_column(input int unsigned x, input int unsigned y,
                                        input int unsigned h, input logic [COLOR_W-1:0] c);
        bit bad;
        int unsigned i;
        bad = 1'b0;
        for (i = 0; i < h; i++)
            bad |= paint_nibble(x, y + i, c);
        return bad;
    endfunction

    function automatic draw_result_t apply_draw_cmd(input draw_cmd_t c);
        draw_result_t r;
        int unsigned xs;
        int unsigned ys;
        int unsigned ws;
        int unsigned hs;
        int unsigned i;
        int unsigned addr;
        bit bad;
        r = '{8'h00, 1'b0};
        bad = 1'b0;
        xs = c.x_pos;
        ys = c.y_pos;
        ws = c.width;
        hs = c.height;
        case (c.command)
            CMD_HLINE: bad = paint_row(xs, ys, ws, c.color);
            CMD_VLINE: bad = paint_column(xs, ys, hs, c.color);
            CMD_BAR:
            begin
                if (ws != 0)
                    for (i = 0; i < hs; i++)
                        bad |= paint_row(xs, ys + i, ws, fill_color);
            end
            CMD_RECT:
            begin
                if (ws != 0 && hs != 0)
                begin
                    bad |= paint_row(xs, ys, ws, fill_color);
                    bad |= paint_row(xs, ys + hs - 1, ws, fill_color);
                    bad |= paint_column(xs, ys, hs, fill_color);
                    bad |= paint_column(xs + ws - 1, ys, hs, fill_color);
                end
            end
            CMD_READ:
            begin
                addr = ys * line_stride + (xs >> 1);
                if (addr >= STORE_BYTES_DEF)
                    bad = 1'b1;
                else
                    r.read_data = frame_img[addr];
            end
            default: ;
        endcase
        r.status = bad;
        return r;
    endfunction

    function automatic draw_cmd_t random_cmd();
        draw_cmd_t c;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 3)
            c.command = CMD_READ + 3'($urandom_range(3, 1));
        else if (pick < 30)
            c.command = CMD_READ;
        else if (pick < 48)
            c.command = CMD_HLINE;
        else if (pick < 64)
            c.command = CMD_VLINE;
        else if (pick < 82)
            c.command = CMD_BAR;
        else
            c.command = CMD_RECT;
        c.x_pos = ($urandom_range(3) != 0) ? X_W'($urandom_range(63)) : X_W'($urandom_range(511));
        c.y_pos = ($urandom_range(3) != 0) ? Y_W'($urandom_range(31)) : Y_W'($urandom_range(255));
        c.color = COLOR_W'($urandom_range(15));
        if (c.command == CMD_READ || c.command > CMD_READ)
        begin
            c.width  = WID_W'($urandom);
            c.height = HGT_W'($urandom);
        end
        else if ($urandom_range(99) < 4)
        begin
            c.width  = WID_W'($urandom_range(1023));
            c.height = HGT_W'($urandom_range(511));
            // keep large bars thin so the run stays short
            if (c.command == CMD_BAR)
            begin
                if ($urandom_range(1) != 0)
                    c.height = HGT_W'($urandom_range(6));
                else
                    c.width = WID_W'($urandom_range(6));
            end
        end
        else
        begin
            c.width  = WID_W'($urandom_range(24));
            c.height = HGT_W'($urandom_range(12));
        end
        return c;
    endfunction

    task automatic flag_error(input string what);
        err_count++;
        if (err_count <= 10)
            $display("ERROR: %s", what);
    endtask

    task automatic push_cmd(input draw_cmd_t c, input logic fixed, input draw_result_t want);
        if ($urandom_range(99) < send_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        cmd_ch.valid   <= 1'b1;
        cmd_ch.command <= c.command;
        cmd_ch.x_pos   <= c.x_pos;
        cmd_ch.y_pos   <= c.y_pos;
        cmd_ch.width   <= c.width;
        cmd_ch.height  <= c.height;
        cmd_ch.color   <= c.color;
        tag_fixed      <= fixed;
        tag_want       <= want;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
    endtask

    task automatic finish_phase();
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_regs(input logic [CFG_DATA_W-1:0] stride_val,
                            input logic [CFG_DATA_W-1:0] color_val);
        cfg_we    <= 1'b1;
        cfg_index <= REG_BYTES_PER_LINE;
        cfg_data  <= stride_val;
        @(posedge clk);
        cfg_index <= REG_DRAW_COLOR;
        cfg_data  <= color_val;
        @(posedge clk);
        cfg_we <= 1'b0;
        line_stride = stride_val;
        fill_color  = color_val[COLOR_W-1:0];
        settings_done++;
    endtask

    always @(posedge clk)
    begin : accept_mon
        draw_result_t want;
        if (rst_n && cmd_ch.valid && cmd_ch.ready)
        begin
            want = apply_draw_cmd('{cmd_ch.command, cmd_ch.x_pos, cmd_ch.y_pos,
                                    cmd_ch.width, cmd_ch.height, cmd_ch.color});
            if (tag_fixed)
                want = tag_want;
            pending_results.push_back(want);
            items_in++;
            if (cmd_ch.command == CMD_READ)
                reads_in++;
            if (want.status)
                flagged_in++;
        end
    end

    always @(posedge clk)
    begin : result_mon
        draw_result_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            results_out++;
            if (pending_results.size() == 0)
                flag_error($sformatf("result %0d with nothing pending: read_data %02h status %0b",
                                     results_out, res_ch.read_data, res_ch.status));
            else
            begin
                want = pending_results.pop_front();
                if (res_ch.read_data !== want.read_data || res_ch.status !== want.status)
                    flag_error($sformatf("result %0d: read_data exp %02h got %02h, status exp %0b got %0b",
                                         results_out, want.read_data, res_ch.read_data,
                                         want.status, res_ch.status));
            end
        end
        res_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    initial
    begin
        #80000000;
        $display("packed_nibble_rect_fill_unit_tb: errors");
        $finish;
    end

    initial
    begin : main_seq
        int p;
        int n;
        logic [CFG_DATA_W-1:0] stride_val;
        logic [CFG_DATA_W-1:0] color_val;

        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = REG_BYTES_PER_LINE;
        cfg_data       = '0;
        cmd_ch.valid   = 1'b0;
        cmd_ch.command = CMD_HLINE;
        cmd_ch.x_pos   = '0;
        cmd_ch.y_pos   = '0;
        cmd_ch.width   = '0;
        cmd_ch.height  = '0;
        cmd_ch.color   = '0;
        res_ch.ready   = 1'b0;
        tag_fixed      = 1'b0;
        tag_want       = '0;
        send_idle_pct  = 0;
        stall_pct      = 0;
        err_count      = 0;
        items_in       = 0;
        results_out    = 0;
        reads_in       = 0;
        flagged_in     = 0;
        settings_done  = 0;
        line_stride    = BPL_RESET;
        fill_color     = COLOR_RESET;
        for (n = 0; n < STORE_BYTES_DEF; n++)
            frame_img[n] = '0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        for (n = 0; n < DIR_ROWS; n++)
            push_cmd(directed_rows[n].cmd, directed_rows[n].fixed, directed_rows[n].want);
        finish_phase();

        for (p = 0; p < PHASES; p++)
        begin
            color_val = CFG_DATA_W'($urandom);
            case (p)
                0: begin stride_val = 8'd1;   color_val = 8'h00; end
                1: begin stride_val = 8'd255; color_val = 8'hFF; end
                2: stride_val = 8'd0;
                3: stride_val = BPL_RESET;
                4: stride_val = CFG_DATA_W'($urandom_range(254, 2));
                5: stride_val = 8'd16;
                default: stride_val = 8'd64;
            endcase
            set_regs(stride_val, color_val);
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 50; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 50; end
                default: begin send_idle_pct = 33; stall_pct = 33; end
            endcase
            for (n = 0; n < PHASE_ITEMS; n++)
                push_cmd(random_cmd(), 1'b0, '0);
            finish_phase();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
            flag_error($sformatf("%0d results never arrived", pending_results.size()));

        $display("run covered %0d items (%0d byte reads, %0d touching addresses off the store)",
                 items_in, reads_in, flagged_in);
        $display("%0d register settings, strides 0/1/255 included; %0d results, %0d mismatches",
                 settings_done, results_out, err_count);
        if (err_count == 0)
            $display("packed_nibble_rect_fill_unit_tb: clean");
        else
            $display("packed_nibble_rect_fill_unit_tb: errors");
        $finish;
    end
endmodule

/* packed_nibble_rect_fill_unit.f */
src/pnrf_pkg.sv
src/pnrf_if.sv
src/pnrf_addr.sv
src/pnrf_mem.sv
src/pnrf_seq.sv
src/packed_nibble_rect_fill_unit.sv
sim/packed_nibble_rect_fill_unit_tb.sv
